[rtl/rmfw_pkg.sv]
// shared types, status codes and defaults for the recursive mutex with fifo waiters
package rmfw_pkg;

   // fixed field widths
   localparam int ID_W     = 8;
   localparam int STATUS_W = 4;
   localparam int ID_SPACE = 1 << ID_W;

   // parameter defaults
   localparam int MAX_THREADS_DEF = 256;
   localparam int NEST_MAX_DEF    = 255;

   // request opcodes
   localparam logic OP_ACQUIRE = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_ACQUIRED     = 4'd0;
   localparam logic [STATUS_W-1:0] ST_NESTED_ACQ   = 4'd1;
   localparam logic [STATUS_W-1:0] ST_QUEUED       = 4'd2;
   localparam logic [STATUS_W-1:0] ST_NESTED_REL   = 4'd3;
   localparam logic [STATUS_W-1:0] ST_FREED        = 4'd4;
   localparam logic [STATUS_W-1:0] ST_HANDED       = 4'd5;
   localparam logic [STATUS_W-1:0] ST_NOT_HOLDER   = 4'd6;
   localparam logic [STATUS_W-1:0] ST_ALREADY_WAIT = 4'd7;
   localparam logic [STATUS_W-1:0] ST_NEST_OVF     = 4'd8;

   // request payload
   typedef struct packed {
      logic            opcode;
      logic [ID_W-1:0] thread_id;
   } req_type;

   // result payload
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                woken_valid;
      logic [ID_W-1:0]     woken_thread;
   } rsp_type;

   // state update selected for one request
   typedef struct packed {
      logic grant;
      logic nest_inc;
      logic nest_dec;
      logic enqueue;
      logic dequeue;
      logic free;
   } action_type;

endpackage

[rtl/rmfw_ram.sv]
// generic single write port ram with one registered read port
module rmfw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, old data on a same-address write
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/rmfw_decide.sv]
// decision logic: picks the status and state update for one lock request
module rmfw_decide
   import rmfw_pkg::*;
#(
   parameter int MAX_THREADS = MAX_THREADS_DEF,
   parameter int NEST_MAX    = NEST_MAX_DEF,
   localparam int DW = $clog2(NEST_MAX + 1),
   localparam int CW = $clog2(MAX_THREADS + 1)
) (
   input  req_type             req,
   input  logic                holder_valid,
   input  logic [ID_W-1:0]     holder_id,
   input  logic [DW-1:0]       nest_depth,
   input  logic [CW-1:0]       queue_count,
   input  logic                waiting,
   output action_type          action,
   output logic [STATUS_W-1:0] status
);

   localparam logic [DW-1:0] NEST_LIMIT = DW'(NEST_MAX);
   localparam logic [DW-1:0] DEPTH_ONE  = DW'(1);
   localparam logic [CW-1:0] QUEUE_FULL = CW'(MAX_THREADS);

   logic is_holder;

   assign is_holder = holder_valid && (holder_id == req.thread_id);

   // request decision
   always_comb begin
      action = '0;
      status = ST_NOT_HOLDER;
      case (req.opcode)
         OP_ACQUIRE: begin
            if (!holder_valid) begin
               action.grant = 1'b1;
               status       = ST_ACQUIRED;
            end else if (is_holder) begin
               if (nest_depth >= NEST_LIMIT) begin
                  status = ST_NEST_OVF;
               end else begin
                  action.nest_inc = 1'b1;
                  status          = ST_NESTED_ACQ;
               end
            end else if (waiting || (queue_count >= QUEUE_FULL)) begin
               status = ST_ALREADY_WAIT;
            end else begin
               action.enqueue = 1'b1;
               status         = ST_QUEUED;
            end
         end
         OP_RELEASE: begin
            if (!is_holder) begin
               status = ST_NOT_HOLDER;
            end else if (nest_depth > DEPTH_ONE) begin
               action.nest_dec = 1'b1;
               status          = ST_NESTED_REL;
            end else if (queue_count != '0) begin
               action.dequeue = 1'b1;
               status         = ST_HANDED;
            end else begin
               action.free = 1'b1;
               status      = ST_FREED;
            end
         end
         default: begin
            status = ST_NOT_HOLDER;
         end
      endcase
   end

endmodule

[rtl/recursive_mutex_fifo_waiters.sv]
// top level of the recursive mutex with a fifo queue of waiting threads
//
// Requests enter on the req_ channel (opcode 0 acquire, 1 release, plus the
// thread id); every request gives exactly one result on the rsp_ channel
// with a status code and, on a hand-off, the thread that now owns the lock.
// A request is registered on transfer in the input register, decided by
// short logic and lands in the result register, which drives rsp_valid.
// Throughput is one request per cycle while rsp_ready stays high, with one
// exception: a hand-off release that arrives right after the queue head
// moves (a previous hand-off, or an enqueue into the empty queue). The head
// entry is read from the wait queue ram through its registered read port,
// so that release is held until the new head has been read; back-to-back
// hand-offs therefore each wait for that read.
// Reset frees the lock, empties the queue and clears all waiting marks at
// once; the queue ram itself is not cleared and needs no sweep.
// When the receiver holds rsp_ready low the finished result stays in the
// output register, one more request is held in the input register, and
// req_ready drops until the result is taken.
module recursive_mutex_fifo_waiters
   import rmfw_pkg::*;
#(
   parameter int MAX_THREADS = MAX_THREADS_DEF,
   parameter int NEST_MAX    = NEST_MAX_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int DW = $clog2(NEST_MAX + 1);
   localparam int CW = $clog2(MAX_THREADS + 1);
   localparam int QW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
   localparam logic [QW-1:0] LAST_SLOT = QW'(MAX_THREADS - 1);
   localparam logic [DW-1:0] DEPTH_ONE = DW'(1);
   localparam logic [CW-1:0] COUNT_ONE = CW'(1);

   // input and output registers
   logic    in_valid_ff, in_valid_in;
   req_type in_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_ff, out_in;

   // lock state
   logic                holder_valid_ff, holder_valid_in;
   logic [ID_W-1:0]     holder_id_ff, holder_id_in;
   logic [DW-1:0]       nest_depth_ff, nest_depth_in;
   logic [QW-1:0]       queue_head_ff, queue_head_in;
   logic [QW-1:0]       queue_tail_ff, queue_tail_in;
   logic [CW-1:0]       queue_count_ff, queue_count_in;
   logic [ID_SPACE-1:0] waiting_ff, waiting_in;
   logic                head_fresh_ff, head_fresh_in;

   action_type          action;
   logic [STATUS_W-1:0] status;
   logic [ID_W-1:0]     head_data;
   logic                fire;
   logic                q_wr_en;

   function automatic logic [QW-1:0] next_slot(input logic [QW-1:0] idx);
      next_slot = (idx == LAST_SLOT) ? '0 : idx + QW'(1);
   endfunction

   rmfw_decide #(
      .MAX_THREADS (MAX_THREADS),
      .NEST_MAX    (NEST_MAX)
   ) u_decide (
      .req          (in_ff),
      .holder_valid (holder_valid_ff),
      .holder_id    (holder_id_ff),
      .nest_depth   (nest_depth_ff),
      .queue_count  (queue_count_ff),
      .waiting      (waiting_ff[in_ff.thread_id]),
      .action       (action),
      .status       (status)
   );

   rmfw_ram #(
      .WIDTH (ID_W),
      .DEPTH (MAX_THREADS)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (q_wr_en),
      .wr_addr (queue_tail_ff),
      .wr_data (in_ff.thread_id),
      .rd_addr (queue_head_ff),
      .rd_data (head_data)
   );

   // a request is decided when the result slot frees and, on hand-off,
   // the head entry read is current
   assign fire      = in_valid_ff && (!out_valid_ff || rsp_ready)
                      && !(action.dequeue && !head_fresh_ff);
   assign req_ready = !in_valid_ff || fire;
   assign q_wr_en   = fire && action.enqueue;

   // handshake registers
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (fire) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // result payload
   always_comb begin
      out_in.status       = status;
      out_in.woken_valid  = action.dequeue;
      out_in.woken_thread = action.dequeue ? head_data : '0;
   end

   // lock and queue state update
   always_comb begin
      holder_valid_in = holder_valid_ff;
      holder_id_in    = holder_id_ff;
      nest_depth_in   = nest_depth_ff;
      queue_head_in   = queue_head_ff;
      queue_tail_in   = queue_tail_ff;
      queue_count_in  = queue_count_ff;
      waiting_in      = waiting_ff;
      if (fire) begin
         if (action.grant) begin
            holder_valid_in = 1'b1;
            holder_id_in    = in_ff.thread_id;
            nest_depth_in   = DEPTH_ONE;
         end
         if (action.nest_inc) begin
            nest_depth_in = nest_depth_ff + DEPTH_ONE;
         end
         if (action.nest_dec) begin
            nest_depth_in = nest_depth_ff - DEPTH_ONE;
         end
         if (action.enqueue) begin
            queue_tail_in               = next_slot(queue_tail_ff);
            queue_count_in              = queue_count_ff + COUNT_ONE;
            waiting_in[in_ff.thread_id] = 1'b1;
         end
         if (action.dequeue) begin
            queue_head_in         = next_slot(queue_head_ff);
            queue_count_in        = queue_count_ff - COUNT_ONE;
            waiting_in[head_data] = 1'b0;
            holder_id_in          = head_data;
            nest_depth_in         = DEPTH_ONE;
         end
         if (action.free) begin
            holder_valid_in = 1'b0;
            holder_id_in    = '0;
            nest_depth_in   = '0;
         end
      end
   end

   // head read stays current unless the head moves or its slot is written
   assign head_fresh_in = !(fire && action.dequeue)
                          && !(q_wr_en && (queue_tail_ff == queue_head_ff));

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         holder_valid_ff <= 1'b0;
         holder_id_ff    <= '0;
         nest_depth_ff   <= '0;
         queue_head_ff   <= '0;
         queue_tail_ff   <= '0;
         queue_count_ff  <= '0;
         waiting_ff      <= '0;
         head_fresh_ff   <= 1'b0;
      end else begin
         in_valid_ff     <= in_valid_in;
         out_valid_ff    <= out_valid_in;
         holder_valid_ff <= holder_valid_in;
         holder_id_ff    <= holder_id_in;
         nest_depth_ff   <= nest_depth_in;
         queue_head_ff   <= queue_head_in;
         queue_tail_ff   <= queue_tail_in;
         queue_count_ff  <= queue_count_in;
         waiting_ff      <= waiting_in;
         head_fresh_ff   <= head_fresh_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
      if (fire) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule
